>>> hw/rtl/dwsp_pkg.sv
// shared constants, types and register codes of the differential wheel speed pid unit
package dwsp_pkg;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int SPEED_WIDTH    = 12;

  localparam int STEER_W = 12;
  localparam int DIST_W  = 9;
  localparam int HEAD_W  = 9;
  localparam int TICK_W  = 16;
  localparam int GAIN_W  = 12;
  localparam int CEIL_W  = 10;
  localparam int DUTY_W  = 11;
  localparam int PWM_W   = 10;
  localparam int CFG_W   = 12;
  localparam int IDX_W   = 3;
  localparam int SPD_W   = 8;

  // error path widths
  localparam int ERR_W  = 14;
  localparam int TGT_W  = 14;
  localparam int RAW_W  = ((TGT_W > SPEED_WIDTH) ? TGT_W : SPEED_WIDTH) + 1;
  localparam int DD_W   = ERR_W + 3;
  localparam int TERM_W = DD_W + GAIN_W - GAIN_FRAC_BITS + 1;
  localparam int SUM_W  = TERM_W + 2;

  // divide by three through a reciprocal, exact for magnitudes below 2**DIV3_SHIFT
  localparam int DIV3_SHIFT = 17;
  localparam int DIV3_W     = 16;
  localparam int DIV3_MUL   = ((2 ** DIV3_SHIFT) + 2) / 3;
  localparam int Q3_W       = STEER_W + DIV3_W - DIV3_SHIFT;

  localparam int BASE_SPEED     = 110;
  localparam int SLOW_SPEED     = 70;
  localparam int SLOWER_SPEED   = 50;
  localparam int SLOW_MEAN      = 160;
  localparam int SLOWER_MEAN    = 180;
  localparam int MID_SPEED      = 150;
  localparam int HIGH_SPEED     = 230;
  localparam int HEAD_LIMIT     = 90;
  localparam int MID_DIST_LO    = 60;
  localparam int MID_DIST_HI    = 100;
  localparam int RECOVER_TICKS  = 100;

  localparam int STEER_CENTER_RST = 1530;
  localparam int GAIN_PROP_RST    = 1536;
  localparam int GAIN_INTEG_RST   = 154;
  localparam int GAIN_DERIV_RST   = 154;
  localparam int DUTY_CEILING_RST = 950;
  localparam int DUTY_FLOOR_RST   = -300;

  typedef enum logic [IDX_W-1:0] {
    REG_STEER_CENTER = 3'd0,
    REG_GAIN_PROP    = 3'd1,
    REG_GAIN_INTEG   = 3'd2,
    REG_GAIN_DERIV   = 3'd3,
    REG_DUTY_CEILING = 3'd4,
    REG_DUTY_FLOOR   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [STEER_W-1:0]       steer_center;
    logic [GAIN_W-1:0]        gain_prop;
    logic [GAIN_W-1:0]        gain_integ;
    logic [GAIN_W-1:0]        gain_deriv;
    logic [CEIL_W-1:0]        duty_ceiling;
    logic signed [DUTY_W-1:0] duty_floor;
  } cfg_t;

  // stage load strobes, one per pipeline stage
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
  } pipe_ld_t;

  typedef struct packed {
    logic signed [TGT_W-1:0]       target;
    logic signed [SPEED_WIDTH-1:0] meas;
  } wheel_t;

endpackage

>>> hw/rtl/dwsp_tick_if.sv
// input channel carrying one control tick word
interface dwsp_tick_if import dwsp_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] left_wheel_speed;
  logic signed [SPEED_WIDTH-1:0] right_wheel_speed;
  logic [STEER_W-1:0]            steer_pulse;
  logic [DIST_W-1:0]             target_distance;
  logic signed [HEAD_W-1:0]      heading_error;
  logic                          mid_boost_enable;
  logic                          high_boost_enable;
  logic                          obstacle_seen;
  logic                          stop_request;
  logic                          recover_ready;
  logic [TICK_W-1:0]             system_ticks;

  modport source (
    output valid, left_wheel_speed, right_wheel_speed, steer_pulse, target_distance,
           heading_error, mid_boost_enable, high_boost_enable, obstacle_seen,
           stop_request, recover_ready, system_ticks,
    input  ready
  );

  modport sink (
    input  valid, left_wheel_speed, right_wheel_speed, steer_pulse, target_distance,
           heading_error, mid_boost_enable, high_boost_enable, obstacle_seen,
           stop_request, recover_ready, system_ticks,
    output ready
  );
endinterface

>>> hw/rtl/dwsp_motor_if.sv
// output channel carrying one motor drive word
interface dwsp_motor_if import dwsp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DUTY_W-1:0] left_duty;
  logic signed [DUTY_W-1:0] right_duty;
  logic [PWM_W-1:0]         left_forward_pwm;
  logic [PWM_W-1:0]         left_reverse_pwm;
  logic [PWM_W-1:0]         right_forward_pwm;
  logic [PWM_W-1:0]         right_reverse_pwm;
  logic                     stopped;

  modport source (
    output valid, left_duty, right_duty, left_forward_pwm, left_reverse_pwm,
           right_forward_pwm, right_reverse_pwm, stopped,
    input  ready
  );

  modport sink (
    input  valid, left_duty, right_duty, left_forward_pwm, left_reverse_pwm,
           right_forward_pwm, right_reverse_pwm, stopped,
    output ready
  );
endinterface

>>> hw/rtl/dwsp_front.sv
// speed choice, steering differential and per-wheel target speeds
module dwsp_front import dwsp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  pipe_ld_t                      ld,
  input  cfg_t                          cfg,
  input  logic signed [SPEED_WIDTH-1:0] left_wheel_speed,
  input  logic signed [SPEED_WIDTH-1:0] right_wheel_speed,
  input  logic [STEER_W-1:0]            steer_pulse,
  input  logic [DIST_W-1:0]             target_distance,
  input  logic signed [HEAD_W-1:0]      heading_error,
  input  logic                          mid_boost_enable,
  input  logic                          high_boost_enable,
  input  logic                          obstacle_seen,
  input  logic                          stop_request,
  input  logic                          recover_ready,
  input  logic [TICK_W-1:0]             system_ticks,
  output wheel_t                        left,
  output wheel_t                        right,
  output logic                          stop
);

  logic signed [STEER_W:0]             d;
  logic [STEER_W-1:0]                  mag;
  logic [STEER_W+DIV3_W-1:0]           p3;
  logic [STEER_W+DIV3_W:0]             p23;
  logic [HEAD_W-1:0]                   ahead;
  logic                                head_ok;
  logic                                mid_mode;
  logic                                high_mode;
  logic [SPD_W-1:0]                    speed_c;
  logic signed [SPEED_WIDTH:0]         sum;
  logic signed [SPEED_WIDTH:0]         sum_rnd;
  logic                                stop_c;

  logic signed [SPEED_WIDTH-1:0]       mean_speed;
  logic [SPD_W-1:0]                    speed1;
  logic [Q3_W-1:0]                     q3_1;
  logic [Q3_W:0]                       q23_1;
  logic                                neg1;
  logic                                boost1;
  logic                                obst1;
  logic                                stop1;
  logic signed [SPEED_WIDTH-1:0]       lsp1;
  logic signed [SPEED_WIDTH-1:0]       rsp1;

  logic [Q3_W:0]                       dmag;
  logic signed [TGT_W-1:0]             diff;
  logic signed [TGT_W-1:0]             speed_s;

  assign d   = $signed({1'b0, steer_pulse}) - $signed({1'b0, cfg.steer_center});
  assign mag = d[STEER_W] ? STEER_W'(-d) : d[STEER_W-1:0];
  assign p3  = mag * DIV3_W'(DIV3_MUL);
  assign p23 = {mag, 1'b0} * DIV3_W'(DIV3_MUL);

  assign ahead   = heading_error[HEAD_W-1] ? HEAD_W'(-heading_error) : heading_error;
  assign head_ok = ahead < HEAD_W'(HEAD_LIMIT);

  assign mid_mode  = mid_boost_enable && (target_distance > DIST_W'(MID_DIST_LO)) &&
                     (target_distance <= DIST_W'(MID_DIST_HI)) && head_ok;
  assign high_mode = !mid_mode && high_boost_enable &&
                     (target_distance > DIST_W'(MID_DIST_HI)) && head_ok;

  always_comb begin
    speed_c = SPD_W'(BASE_SPEED);
    if (int'(mean_speed) > SLOW_MEAN) speed_c = SPD_W'(SLOW_SPEED);
    if (int'(mean_speed) > SLOWER_MEAN) speed_c = SPD_W'(SLOWER_SPEED);
    if (mid_mode) speed_c = SPD_W'(MID_SPEED);
    else if (high_mode) speed_c = SPD_W'(HIGH_SPEED);
  end

  // mean of both wheels, truncated toward zero
  assign sum     = (SPEED_WIDTH+1)'(left_wheel_speed) + (SPEED_WIDTH+1)'(right_wheel_speed);
  assign sum_rnd = sum + $signed({{SPEED_WIDTH{1'b0}}, sum[SPEED_WIDTH]});

  assign stop_c = stop_request && !(recover_ready && (system_ticks < TICK_W'(RECOVER_TICKS)));

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_speed <= '0;
    end else if (ld.ld1) begin
      mean_speed <= sum_rnd[SPEED_WIDTH:1];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      speed1 <= speed_c;
      q3_1   <= p3[DIV3_SHIFT +: Q3_W];
      q23_1  <= p23[DIV3_SHIFT +: Q3_W+1];
      neg1   <= d[STEER_W];
      boost1 <= mid_mode || high_mode;
      obst1  <= obstacle_seen;
      stop1  <= stop_c;
      lsp1   <= left_wheel_speed;
      rsp1   <= right_wheel_speed;
    end
  end

  // obstacle takes d/3, boost modes d/6, otherwise 2d/3
  always_comb begin
    if (obst1) dmag = {1'b0, q3_1};
    else if (boost1) dmag = {2'b00, q3_1[Q3_W-1:1]};
    else dmag = q23_1;
  end

  assign diff    = neg1 ? -$signed(TGT_W'(dmag)) : $signed(TGT_W'(dmag));
  assign speed_s = $signed(TGT_W'(speed1));

  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      left.target  <= stop1 ? '0 : speed_s - diff;
      right.target <= stop1 ? '0 : speed_s + diff;
      left.meas    <= lsp1;
      right.meas   <= rsp1;
      stop         <= stop1;
    end
  end

endmodule

>>> hw/rtl/dwsp_lane.sv
// one wheel's incremental pid: error history, gain products and clamped duty accumulator
module dwsp_lane import dwsp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  pipe_ld_t                 ld,
  input  cfg_t                     cfg,
  input  wheel_t                   wheel,
  output logic signed [DUTY_W-1:0] duty_next
);

  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

  // product shifted down with truncation toward zero
  function automatic logic signed [TERM_W-1:0] tz(input logic signed [DD_W-1:0] x,
                                                  input logic [GAIN_W-1:0] g);
    logic [DD_W-1:0]        m;
    logic [DD_W+GAIN_W-1:0] p;
    logic signed [TERM_W-1:0] q;
    m = x[DD_W-1] ? DD_W'(-x) : x;
    p = m * g;
    q = $signed(TERM_W'(p >> GAIN_FRAC_BITS));
    return x[DD_W-1] ? -q : q;
  endfunction

  logic signed [RAW_W-1:0]  raw;
  logic signed [ERR_W-1:0]  e0c;
  logic signed [DD_W-1:0]   dp_c;
  logic signed [DD_W-1:0]   dd_c;
  logic signed [ERR_W-1:0]  e1;
  logic signed [ERR_W-1:0]  e2;
  logic signed [ERR_W-1:0]  e0_r;
  logic signed [DD_W-1:0]   dp_r;
  logic signed [DD_W-1:0]   dd_r;
  logic signed [TERM_W-1:0] tp;
  logic signed [TERM_W-1:0] ti;
  logic signed [TERM_W-1:0] td;
  logic signed [DUTY_W-1:0] acc;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  capped;
  logic signed [SUM_W-1:0]  ceil_s;
  logic signed [SUM_W-1:0]  floor_s;

  assign raw = RAW_W'(wheel.target) - RAW_W'(wheel.meas);

  always_comb begin
    if (raw > RAW_W'(ERR_MAX)) e0c = ERR_MAX;
    else if (raw < RAW_W'(ERR_MIN)) e0c = ERR_MIN;
    else e0c = raw[ERR_W-1:0];
  end

  assign dp_c = DD_W'(e0c) - DD_W'(e1);
  assign dd_c = DD_W'(e0c) - (DD_W'(e1) <<< 1) + DD_W'(e2);

  always_ff @(posedge clk) begin
    if (rst) begin
      e1 <= '0;
      e2 <= '0;
    end else if (ld.ld3) begin
      e1 <= e0c;
      e2 <= e1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      e0_r <= e0c;
      dp_r <= dp_c;
      dd_r <= dd_c;
    end
    if (ld.ld4) begin
      tp <= tz(dp_r, cfg.gain_prop);
      ti <= tz(DD_W'(e0_r), cfg.gain_integ);
      td <= tz(dd_r, cfg.gain_deriv);
    end
  end

  assign sum     = SUM_W'(acc) + SUM_W'(tp) + SUM_W'(ti) + SUM_W'(td);
  assign ceil_s  = $signed({{(SUM_W-CEIL_W){1'b0}}, cfg.duty_ceiling});
  assign floor_s = SUM_W'(cfg.duty_floor);

  // ceiling first, then the floor wins
  always_comb begin
    capped = (sum > ceil_s) ? ceil_s : sum;
    if (capped <= floor_s) capped = floor_s;
  end

  assign duty_next = capped[DUTY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ld.ld5) begin
      acc <= duty_next;
    end
  end

endmodule

>>> hw/rtl/dwsp_merge.sv
// joins both lanes into the output word and splits duty into forward and reverse pwm
module dwsp_merge import dwsp_pkg::*; (
  input  logic                     clk,
  input  pipe_ld_t                 ld,
  input  logic                     stop,
  input  logic signed [DUTY_W-1:0] left_next,
  input  logic signed [DUTY_W-1:0] right_next,
  output logic signed [DUTY_W-1:0] left_duty,
  output logic signed [DUTY_W-1:0] right_duty,
  output logic [PWM_W-1:0]         left_forward_pwm,
  output logic [PWM_W-1:0]         left_reverse_pwm,
  output logic [PWM_W-1:0]         right_forward_pwm,
  output logic [PWM_W-1:0]         right_reverse_pwm,
  output logic                     stopped
);

  function automatic logic [PWM_W-1:0] fwd_of(input logic signed [DUTY_W-1:0] d);
    return d[DUTY_W-1] ? '0 : d[PWM_W-1:0];
  endfunction

  // negated duty, pinned at full scale when it does not fit
  function automatic logic [PWM_W-1:0] rev_of(input logic signed [DUTY_W-1:0] d);
    logic signed [DUTY_W:0] n;
    n = -((DUTY_W+1)'(d));
    if (!d[DUTY_W-1]) return '0;
    return (n[DUTY_W:PWM_W] != '0) ? '1 : n[PWM_W-1:0];
  endfunction

  logic stop3;
  logic stop4;

  always_ff @(posedge clk) begin
    if (ld.ld3) stop3 <= stop;
    if (ld.ld4) stop4 <= stop3;
    if (ld.ld5) begin
      left_duty         <= left_next;
      right_duty        <= right_next;
      left_forward_pwm  <= fwd_of(left_next);
      left_reverse_pwm  <= rev_of(left_next);
      right_forward_pwm <= fwd_of(right_next);
      right_reverse_pwm <= rev_of(right_next);
      stopped           <= stop4;
    end
  end

endmodule

>>> hw/rtl/differential_wheel_speed_pid_unit.sv
// Differential drive wheel speed controller: two incremental pid lanes, one per wheel.
// A tick word passes five pipeline stages (speed and differential choice, wheel targets,
// error history, gain products, duty accumulate and output register) before its drive word
// is valid; a new tick word is taken every cycle unless motor.ready stalls the output,
// and each stage holds its word only while the stage after it is full and cannot move on.
// The left and right lanes run side by side, each with three 12x17 gain multipliers, and
// the last stage merges their clamped duties into one drive word. Controller state is
// cleared at reset, no warm-up pass is needed. The user writes configuration registers
// through cfg_we/cfg_idx/cfg_wdata only while idle; the block does not enforce this.
module differential_wheel_speed_pid_unit import dwsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_idx,
  input  logic [CFG_W-1:0]   cfg_wdata,
  dwsp_tick_if.sink          tick,
  dwsp_motor_if.source       motor
);

  cfg_t     cfg;
  pipe_ld_t ld;
  logic     v1, v2, v3, v4, v5;
  logic     can1, can2, can3, can4, can5;
  wheel_t   left_w;
  wheel_t   right_w;
  logic     stop2;
  logic signed [DUTY_W-1:0] left_next;
  logic signed [DUTY_W-1:0] right_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steer_center <= STEER_W'(STEER_CENTER_RST);
      cfg.gain_prop    <= GAIN_W'(GAIN_PROP_RST);
      cfg.gain_integ   <= GAIN_W'(GAIN_INTEG_RST);
      cfg.gain_deriv   <= GAIN_W'(GAIN_DERIV_RST);
      cfg.duty_ceiling <= CEIL_W'(DUTY_CEILING_RST);
      cfg.duty_floor   <= DUTY_W'(DUTY_FLOOR_RST);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_STEER_CENTER: cfg.steer_center <= cfg_wdata[STEER_W-1:0];
        REG_GAIN_PROP:    cfg.gain_prop    <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_INTEG:   cfg.gain_integ   <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_DERIV:   cfg.gain_deriv   <= cfg_wdata[GAIN_W-1:0];
        REG_DUTY_CEILING: cfg.duty_ceiling <= cfg_wdata[CEIL_W-1:0];
        REG_DUTY_FLOOR:   cfg.duty_floor   <= $signed(cfg_wdata[DUTY_W-1:0]);
        default: ;
      endcase
    end
  end

  // a stage can load when empty or when its word moves on this cycle
  assign can5 = !v5 || motor.ready;
  assign can4 = !v4 || can5;
  assign can3 = !v3 || can4;
  assign can2 = !v2 || can3;
  assign can1 = !v1 || can2;

  assign tick.ready = can1;
  assign ld.ld1 = tick.valid && can1;
  assign ld.ld2 = v1 && can2;
  assign ld.ld3 = v2 && can3;
  assign ld.ld4 = v3 && can4;
  assign ld.ld5 = v4 && can5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (can1) v1 <= ld.ld1;
      if (can2) v2 <= ld.ld2;
      if (can3) v3 <= ld.ld3;
      if (can4) v4 <= ld.ld4;
      if (can5) v5 <= ld.ld5;
    end
  end

  assign motor.valid = v5;

  dwsp_front u_front (
    .clk               (clk),
    .rst               (rst),
    .ld                (ld),
    .cfg               (cfg),
    .left_wheel_speed  (tick.left_wheel_speed),
    .right_wheel_speed (tick.right_wheel_speed),
    .steer_pulse       (tick.steer_pulse),
    .target_distance   (tick.target_distance),
    .heading_error     (tick.heading_error),
    .mid_boost_enable  (tick.mid_boost_enable),
    .high_boost_enable (tick.high_boost_enable),
    .obstacle_seen     (tick.obstacle_seen),
    .stop_request      (tick.stop_request),
    .recover_ready     (tick.recover_ready),
    .system_ticks      (tick.system_ticks),
    .left              (left_w),
    .right             (right_w),
    .stop              (stop2)
  );

  dwsp_lane u_lane_left (
    .clk       (clk),
    .rst       (rst),
    .ld        (ld),
    .cfg       (cfg),
    .wheel     (left_w),
    .duty_next (left_next)
  );

  dwsp_lane u_lane_right (
    .clk       (clk),
    .rst       (rst),
    .ld        (ld),
    .cfg       (cfg),
    .wheel     (right_w),
    .duty_next (right_next)
  );

  dwsp_merge u_merge (
    .clk               (clk),
    .ld                (ld),
    .stop              (stop2),
    .left_next         (left_next),
    .right_next        (right_next),
    .left_duty         (motor.left_duty),
    .right_duty        (motor.right_duty),
    .left_forward_pwm  (motor.left_forward_pwm),
    .left_reverse_pwm  (motor.left_reverse_pwm),
    .right_forward_pwm (motor.right_forward_pwm),
    .right_reverse_pwm (motor.right_reverse_pwm),
    .stopped           (motor.stopped)
  );

endmodule
